@@ rtl/rrm_pkg.sv @@
// Shared constants, types and the quarter-wave sine table of the range remapper.
package rrm_pkg;

   // Fraction format and sine table size.
   localparam int FRACTION_BITS = 16;
   localparam int FRAC_W        = FRACTION_BITS + 1;
   localparam int SINE_ENTRIES  = 256;
   localparam int SINE_IDX_BITS = 8;
   localparam int ROM_ADDR_W    = SINE_IDX_BITS + 1;
   localparam int DATA_W        = 16;
   localparam int DIVIDEND_W    = DATA_W + FRACTION_BITS;

   // Divider pipeline shape: quotient bits resolved per stage and stage count.
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = (FRAC_W + DIV_STEPS - 1) / DIV_STEPS;

   localparam logic [FRAC_W-1:0] ONE_FRAC = FRAC_W'(1) << FRACTION_BITS;
   localparam logic [FRAC_W-1:0] HALF_FRAC = FRAC_W'(1) << (FRACTION_BITS - 1);

   // Constants of the table generator (Q2.30).
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned Q30_HALF    = 64'd1 << 29;

   // Curve codes; unused codes behave as linear.
   localparam logic [2:0] CURVE_COSINE     = 3'd0;
   localparam logic [2:0] CURVE_LINEAR     = 3'd1;
   localparam logic [2:0] CURVE_SINE       = 3'd2;
   localparam logic [2:0] CURVE_SQUARE     = 3'd3;
   localparam logic [2:0] CURVE_INV_SQUARE = 3'd4;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_CURVE_MODE    = 3'd0;
   localparam logic [2:0] REG_SOURCE_FIRST  = 3'd1;
   localparam logic [2:0] REG_SOURCE_SECOND = 3'd2;
   localparam logic [2:0] REG_TARGET_FIRST  = 3'd3;
   localparam logic [2:0] REG_TARGET_SECOND = 3'd4;

   // Configuration register contents handed to the datapath.
   typedef struct packed {
      logic [2:0]               curve_mode;
      logic signed [DATA_W-1:0] source_first;
      logic signed [DATA_W-1:0] source_second;
      logic signed [DATA_W-1:0] target_first;
      logic signed [DATA_W-1:0] target_second;
   } csr_type;

   typedef logic [FRAC_W-1:0] rom_type [0:SINE_ENTRIES];

   // Builds the sine table from a fixed-point Taylor series, evaluated at elaboration.
   function automatic rom_type build_sine_rom();
      rom_type         rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned sum;
      longint unsigned term;
      longint unsigned e;
      for (int k = 0; k <= SINE_ENTRIES; k++) begin
         x = (HALF_PI_Q30 * 64'(k) + SINE_ENTRIES / 2) / SINE_ENTRIES;
         x2 = (x * x + Q30_HALF) >> 30;
         sum = x;
         term = x;
         for (int i = 1; i <= 6; i++) begin
            term = (term * x2 + Q30_HALF) >> 30;
            case (i)
               1: term = term / 6;
               2: term = term / 20;
               3: term = term / 42;
               4: term = term / 72;
               5: term = term / 110;
               default: term = term / 156;
            endcase
            if (i[0]) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         e = ((sum << FRACTION_BITS) + Q30_HALF) >> 30;
         rom[k] = (e > 64'(ONE_FRAC)) ? ONE_FRAC : FRAC_W'(e);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_sine_rom();

endpackage

@@ rtl/range_remap_with_easing_top.sv @@
// Top level of the range remapper: clamp, fraction divider, easing and target mapping.
//
// A request is taken on every rising edge where start is high; busy stays low, so a
// new amount may be issued in every cycle. Each request yields exactly one result on
// rsp_mapped_value and rsp_empty_span, marked by rsp_strobe for one cycle.
// Sustained throughput is one request per cycle.
// A request passes through the pipeline: an input register, a clamp stage, five stages
// of the fraction divider (four quotient bits in each but the last, which resolves one),
// three easing stages, the target multiply and the output rounding register.
// The receiver cannot stall; results are presented once and must be taken.
// Configuration lives behind the APB-style port (psel, penable, pwrite, paddr, pwdata,
// prdata, pready). The user must write it only while no request is in flight;
// the block does not enforce this. A synchronous reset empties the pipeline and restores
// the register defaults (linear curve, source and target both 0 to 32767). Equal source
// bounds return target_first with rsp_empty_span set.
module range_remap_with_easing_top import rrm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_amount,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_mapped_value,
   output logic                     rsp_empty_span,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [4:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   csr_type                  csr;
   logic                     a_valid_ff;
   logic signed [DATA_W-1:0] amount_ff;
   logic signed [DATA_W-1:0] src_lo, src_hi, clamped;
   logic signed [DATA_W:0]   dn, dd;
   logic [DATA_W-1:0]        num_in, den_in, num_ff, den_ff;
   logic                     b_valid_ff, b_empty_ff, empty_in;
   logic                     div_valid, div_empty;
   logic [FRAC_W-1:0]        div_quo;
   logic                     crv_valid, crv_empty;
   logic [FRAC_W-1:0]        crv_frac;
   logic signed [DATA_W:0]   span;
   logic signed [FRAC_W:0]   g_signed;
   logic signed [DATA_W+FRAC_W+1:0] prod_in, prod_ff, prod_round;
   logic                     p_valid_ff, p_empty_ff;
   logic signed [DATA_W+2:0] q_val;
   logic signed [DATA_W+3:0] r_val;
   logic signed [DATA_W-1:0] r_sat, mapped_in;
   logic                     strobe_ff, empty_ff;
   logic signed [DATA_W-1:0] mapped_ff;

   assign busy = 1'b0;

   rrm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start & ~busy;
      end
      amount_ff <= req_amount;
   end

   // Clamp between the ordered bounds and form offset and span magnitudes.
   always_comb begin
      if (csr.source_first < csr.source_second) begin
         src_lo = csr.source_first;
         src_hi = csr.source_second;
      end else begin
         src_lo = csr.source_second;
         src_hi = csr.source_first;
      end
      clamped = amount_ff;
      if (clamped < src_lo) begin
         clamped = src_lo;
      end
      if (clamped > src_hi) begin
         clamped = src_hi;
      end
      dn = (DATA_W+1)'(clamped) - (DATA_W+1)'(csr.source_first);
      dd = (DATA_W+1)'(csr.source_second) - (DATA_W+1)'(csr.source_first);
      num_in = dn[DATA_W] ? DATA_W'(-dn) : dn[DATA_W-1:0];
      den_in = dd[DATA_W] ? DATA_W'(-dd) : dd[DATA_W-1:0];
      empty_in = (csr.source_first == csr.source_second);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_empty_ff <= empty_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
   end

   rrm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid_ff),
      .in_empty  (b_empty_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .out_valid (div_valid),
      .out_empty (div_empty),
      .out_quo   (div_quo)
   );

   rrm_curve u_curve (
      .clock      (clock),
      .reset      (reset),
      .curve_mode (csr.curve_mode),
      .in_valid   (div_valid),
      .in_empty   (div_empty),
      .in_frac    (div_quo),
      .out_valid  (crv_valid),
      .out_empty  (crv_empty),
      .out_frac   (crv_frac)
   );

   // Scale the eased fraction by the target span.
   assign span     = (DATA_W+1)'(csr.target_second) - (DATA_W+1)'(csr.target_first);
   assign g_signed = $signed({1'b0, crv_frac});
   assign prod_in  = (DATA_W+FRAC_W+2)'(span) * (DATA_W+FRAC_W+2)'(g_signed);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= crv_valid;
      end
      p_empty_ff <= crv_empty;
      prod_ff    <= prod_in;
   end

   // Round half up, add the target base and saturate.
   assign prod_round = prod_ff + (DATA_W+FRAC_W+2)'(HALF_FRAC);
   assign q_val      = prod_round[DATA_W+FRAC_W+1:FRACTION_BITS];
   assign r_val      = (DATA_W+4)'(csr.target_first) + (DATA_W+4)'(q_val);

   always_comb begin
      if (r_val > (DATA_W+4)'(16'sh7fff)) begin
         r_sat = 16'sh7fff;
      end else if (r_val < -(DATA_W+4)'(20'sh08000)) begin
         r_sat = 16'sh8000;
      end else begin
         r_sat = r_val[DATA_W-1:0];
      end
      mapped_in = p_empty_ff ? csr.target_first : r_sat;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= p_valid_ff;
      end
      empty_ff  <= p_empty_ff;
      mapped_ff <= mapped_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_empty_span   = empty_ff;
   assign rsp_mapped_value = mapped_ff;

   // Every result traces back to an earlier request.
   a_result_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 12))
      else $error("result without a matching request");

   // An empty source span returns the target base unchanged.
   a_empty_gives_base: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_empty_span |-> rsp_mapped_value == csr.target_first)
      else $error("empty span did not return target_first");

   // A request entering an empty pipeline reaches the divider through the input and clamp registers.
   a_div_fed: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> $past(start, 2))
      else $error("divider fed without a request");

endmodule

@@ rtl/rrm_csr.sv @@
// Configuration register file with its APB-style access port.
module rrm_csr import rrm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output csr_type     csr
);

   csr_type     csr_ff;
   logic [2:0]  reg_index;
   logic        write_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign write_en  = psel & penable & pwrite;
   assign csr       = csr_ff;

   // Register writes; writes beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.curve_mode    <= CURVE_LINEAR;
         csr_ff.source_first  <= 16'sd0;
         csr_ff.source_second <= 16'sd32767;
         csr_ff.target_first  <= 16'sd0;
         csr_ff.target_second <= 16'sd32767;
      end else if (write_en) begin
         unique case (reg_index)
            REG_CURVE_MODE:    csr_ff.curve_mode    <= pwdata[2:0];
            REG_SOURCE_FIRST:  csr_ff.source_first  <= pwdata[15:0];
            REG_SOURCE_SECOND: csr_ff.source_second <= pwdata[15:0];
            REG_TARGET_FIRST:  csr_ff.target_first  <= pwdata[15:0];
            REG_TARGET_SECOND: csr_ff.target_second <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read-back multiplexer.
   always_comb begin
      unique case (reg_index)
         REG_CURVE_MODE:    prdata = {29'd0, csr_ff.curve_mode};
         REG_SOURCE_FIRST:  prdata = {16'd0, csr_ff.source_first};
         REG_SOURCE_SECOND: prdata = {16'd0, csr_ff.source_second};
         REG_TARGET_FIRST:  prdata = {16'd0, csr_ff.target_first};
         REG_TARGET_SECOND: prdata = {16'd0, csr_ff.target_second};
         default:           prdata = 32'd0;
      endcase
   end

endmodule

@@ rtl/rrm_div.sv @@
// Pipelined restoring divider that turns the clamped offset into a rounded fraction.
module rrm_div import rrm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              in_empty,
   input  logic [DATA_W-1:0] in_num,
   input  logic [DATA_W-1:0] in_den,
   output logic              out_valid,
   output logic              out_empty,
   output logic [FRAC_W-1:0] out_quo
);

   typedef struct packed {
      logic              valid;
      logic              empty;
      logic [DATA_W-1:0] rem;
      logic [FRAC_W-1:0] bits;
      logic [FRAC_W-1:0] quo;
      logic [DATA_W-1:0] den;
   } div_stage_type;

   div_stage_type           stage_src [DIV_STAGES];
   div_stage_type           stage_in  [DIV_STAGES];
   div_stage_type           stage_ff  [DIV_STAGES];
   logic [DIVIDEND_W-1:0]   dividend;

   // Dividend carries the rounding half of the divisor.
   assign dividend = {in_num, FRACTION_BITS'(0)} + DIVIDEND_W'(in_den >> 1);

   // The top dividend bits are always below a nonzero divisor, so they seed the remainder.
   assign stage_src[0] = '{valid: in_valid, empty: in_empty,
                           rem: DATA_W'(dividend[DIVIDEND_W-1:FRAC_W]),
                           bits: dividend[FRAC_W-1:0], quo: '0, den: in_den};

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      if (s > 0) begin : g_link
         assign stage_src[s] = stage_ff[s-1];
      end

      // Four compare-and-subtract steps per stage (one in the last), one quotient bit each.
      always_comb begin
         div_stage_type       nxt;
         logic [DATA_W:0]     trial;
         nxt = stage_src[s];
         trial = '0;
         for (int t = 0; t < DIV_STEPS; t++) begin
            if (s * DIV_STEPS + t < FRAC_W) begin
               trial = {nxt.rem, nxt.bits[FRAC_W-1]};
               nxt.bits = nxt.bits << 1;
               if (trial >= {1'b0, nxt.den}) begin
                  nxt.rem = DATA_W'(trial - {1'b0, nxt.den});
                  nxt.quo = {nxt.quo[FRAC_W-2:0], 1'b1};
               end else begin
                  nxt.rem = trial[DATA_W-1:0];
                  nxt.quo = {nxt.quo[FRAC_W-2:0], 1'b0};
               end
            end
         end
         stage_in[s] = nxt;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[s] <= '0;
         end else begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign out_valid = stage_ff[DIV_STAGES-1].valid;
   assign out_empty = stage_ff[DIV_STAGES-1].empty;
   assign out_quo   = stage_ff[DIV_STAGES-1].quo;

   // The offset never exceeds the span, so the fraction never exceeds one.
   a_quo_bounded: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_empty |-> out_quo <= ONE_FRAC)
      else $error("divider quotient above one");

endmodule

@@ rtl/rrm_curve.sv @@
// Easing curve stages: table interpolation, squaring and curve selection.
module rrm_curve import rrm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        curve_mode,
   input  logic              in_valid,
   input  logic              in_empty,
   input  logic [FRAC_W-1:0] in_frac,
   output logic              out_valid,
   output logic              out_empty,
   output logic [FRAC_W-1:0] out_frac
);

   logic [FRAC_W-1:0]          frac_c;
   logic [ROM_ADDR_W-1:0]      pos_idx;
   logic [SINE_IDX_BITS-1:0]   idx_low;
   logic [FRACTION_BITS-1:0]   pos_rem;
   logic [FRAC_W-1:0]          lo_val;
   logic [FRAC_W-1:0]          hi_val;
   logic [FRAC_W-1:0]          delta;
   logic [FRAC_W-1:0]          sq_src;
   logic [2*FRAC_W-1:0]        sq_prod;

   logic                       v1_ff, e1_ff, v2_ff, e2_ff, v3_ff, e3_ff;
   logic [FRAC_W-1:0]          lo_ff, sq1_ff, f1_ff;
   logic [FRAC_W+FRACTION_BITS-1:0] dprod_ff;
   logic [FRAC_W+FRACTION_BITS-1:0] dprod_in;
   logic [FRAC_W-1:0]          sq1_in;
   logic [FRAC_W-1:0]          s2_ff, sq2_ff, f2_ff, s2_in;
   logic [2*FRAC_W-1:0]        ss_prod;
   logic [FRAC_W-1:0]          g_in, g_ff;

   // Stage one: table position, neighbors, slope product and the plain square.
   assign frac_c  = (in_frac > ONE_FRAC) ? ONE_FRAC : in_frac;
   assign pos_idx = ROM_ADDR_W'(frac_c >> (FRACTION_BITS - SINE_IDX_BITS));
   assign idx_low = pos_idx[SINE_IDX_BITS-1:0];
   assign pos_rem = {frac_c[FRACTION_BITS-SINE_IDX_BITS-1:0], SINE_IDX_BITS'(0)};

   always_comb begin
      if (pos_idx[SINE_IDX_BITS]) begin
         lo_val = SINE_ROM[SINE_ENTRIES];
         hi_val = SINE_ROM[SINE_ENTRIES];
      end else begin
         lo_val = SINE_ROM[{1'b0, idx_low}];
         hi_val = SINE_ROM[ROM_ADDR_W'(idx_low) + ROM_ADDR_W'(1)];
      end
      delta = (hi_val >= lo_val) ? hi_val - lo_val : '0;
   end

   assign dprod_in = delta * pos_rem;
   assign sq_src   = (curve_mode == CURVE_INV_SQUARE) ? ONE_FRAC - frac_c : frac_c;
   assign sq_prod  = sq_src * sq_src;
   assign sq1_in   = FRAC_W'((sq_prod + (2*FRAC_W)'(HALF_FRAC)) >> FRACTION_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      e1_ff    <= in_empty;
      lo_ff    <= lo_val;
      dprod_ff <= dprod_in;
      sq1_ff   <= sq1_in;
      f1_ff    <= frac_c;
   end

   // Stage two: finish the interpolated sine.
   assign s2_in = lo_ff + FRAC_W'((dprod_ff + (FRAC_W+FRACTION_BITS)'(HALF_FRAC))
                                   >> FRACTION_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      e2_ff  <= e1_ff;
      s2_ff  <= s2_in;
      sq2_ff <= sq1_ff;
      f2_ff  <= f1_ff;
   end

   // Stage three: square the sine for the cosine ease and pick the curve.
   assign ss_prod = s2_ff * s2_ff;

   always_comb begin
      case (curve_mode)
         CURVE_COSINE:     g_in = FRAC_W'((ss_prod + (2*FRAC_W)'(HALF_FRAC)) >> FRACTION_BITS);
         CURVE_SINE:       g_in = s2_ff;
         CURVE_SQUARE:     g_in = sq2_ff;
         CURVE_INV_SQUARE: g_in = ONE_FRAC - sq2_ff;
         default:          g_in = f2_ff;
      endcase
      if (g_in > ONE_FRAC) begin
         g_in = ONE_FRAC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      e3_ff <= e2_ff;
      g_ff  <= g_in;
   end

   assign out_valid = v3_ff;
   assign out_empty = e3_ff;
   assign out_frac  = g_ff;

   // The eased fraction stays within the unit interval.
   a_curve_bounded: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_frac <= ONE_FRAC)
      else $error("eased fraction above one");

endmodule
